>>> hdl/bgnc_pkg.sv
package bgnc_pkg;

	// Largest grid side the line buffer holds
	localparam int MAX_SIZE = 32;

	// Widths fixed by the interface
	localparam int SIZE_W  = 6;
	localparam int COORD_W = 5;
	localparam int CNT_W   = 4;

	// Line buffer: one word per column, the two most recent rows
	localparam int ADDR_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int LINE_W = 2;

	// Row and column position counters, and a common width for size compares
	localparam int POS_W = ADDR_W;
	localparam int CMP_W = (SIZE_W > ADDR_W + 1) ? SIZE_W : ADDR_W + 1;

	localparam int GRID_RESET = 32;

	// Which result the datapath forms in the output register
	typedef enum logic [1:0] {
		EMIT_DIAG,
		EMIT_EDGE,
		EMIT_FLUSH
	} emit_kind_t;

	// Controller to datapath
	typedef struct packed {
		logic       take;
		logic       load;
		logic       fl_read;
		logic       fl_shift;
		logic       emit;
		emit_kind_t kind;
		logic       last;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic e1;
		logic e2;
		logic fl;
		logic fl_first;
		logic fl_last;
		logic out_free;
	} status_t;

endpackage

>>> hdl/binary_grid_neighbor_count.sv
// Streaming 3x3 box sum over a square binary grid of side grid_size (1..32,
// 0 acts as 1, larger values clamp to 32). Cells come in raster order, one
// mine bit per transaction; each result gives a cell's row, column and the
// number of mines in its 3x3 neighbourhood (itself included, off-grid cells
// empty). Results trail the input by one row and one column, and the final
// cell of a grid flushes the whole last row; last marks the final result of
// each input transaction. Writing grid_size restarts the raster at row 0.
// A new cell is taken only once the last is through. A cell releases 0 to 2
// results; after the final cell of a grid each flush result waits for a
// registered line buffer read and a window shift of its own, and the first
// column read only primes the window. A stalled output holds the sequencer.
// The line buffer needs no clearing after reset: rows not yet written in the
// current grid are masked off.
module binary_grid_neighbor_count (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bgnc_pkg::SIZE_W-1:0]   grid_size,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          mine,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bgnc_pkg::COORD_W-1:0]  row_index,
	output logic [bgnc_pkg::COORD_W-1:0]  col_index,
	output logic [bgnc_pkg::CNT_W-1:0]    neighbor_count,
	output logic                          last
);

	bgnc_pkg::cmd_t    cmd;
	bgnc_pkg::status_t sts;

	// Sequencer
	bgnc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cfg_ready(cfg_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Counters, line buffer, window and output register
	bgnc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_data      (grid_size),
		.mine          (mine),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.row_index     (row_index),
		.col_index     (col_index),
		.neighbor_count(neighbor_count),
		.last          (last)
	);

	// One cell at a time: busy straight after taking one
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a cell is still in work");

	// A 3x3 neighbourhood holds at most nine mines
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> neighbor_count <= bgnc_pkg::CNT_W'(9))
		else $error("neighbour count above nine");

	// No result is formed while the block takes a new cell
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !cmd.emit && !cmd.load)
		else $error("datapath busy while idle");

	// A result leaves the sequencer only when the output register can take it
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && sts.out_free |=> out_valid)
		else $error("result lost on its way to the output register");

endmodule

>>> hdl/bgnc_ram.sv
module bgnc_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hdl/bgnc_ctrl.sv
module bgnc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              cfg_ready,
	input  bgnc_pkg::status_t sts,
	output bgnc_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIAG,
		ST_EDGE,
		ST_FRD,
		ST_FSH,
		ST_FEMIT
	} state_t;

	state_t state_q;
	state_t state_d;

	// Where to go once the line buffer has been updated or a result is out
	function automatic state_t after_diag(input bgnc_pkg::status_t s);
		state_t nxt;
		if (s.e2) begin
			nxt = ST_EDGE;
		end else if (s.fl) begin
			nxt = ST_FRD;
		end else begin
			nxt = ST_IDLE;
		end
		return nxt;
	endfunction

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (sts.e1) begin
					state_d = ST_DIAG;
				end else begin
					state_d = after_diag(sts);
				end
			end
			ST_DIAG: begin
				if (sts.out_free) begin
					state_d = after_diag(sts);
				end
			end
			ST_EDGE: begin
				if (sts.out_free) begin
					state_d = sts.fl ? ST_FRD : ST_IDLE;
				end
			end
			ST_FRD: begin
				state_d = ST_FSH;
			end
			ST_FSH: begin
				// first column read only primes the window
				state_d = sts.fl_first ? ST_FRD : ST_FEMIT;
			end
			ST_FEMIT: begin
				if (sts.out_free) begin
					state_d = sts.fl_last ? ST_IDLE : ST_FRD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Commands decoded from state
	always_comb begin
		cmd.take     = 1'b0;
		cmd.load     = 1'b0;
		cmd.fl_read  = 1'b0;
		cmd.fl_shift = 1'b0;
		cmd.emit     = 1'b0;
		cmd.kind     = bgnc_pkg::EMIT_DIAG;
		cmd.last     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.take = in_valid;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
			end
			ST_DIAG: begin
				cmd.emit = 1'b1;
				cmd.kind = bgnc_pkg::EMIT_DIAG;
				cmd.last = !sts.e2 && !sts.fl;
			end
			ST_EDGE: begin
				cmd.emit = 1'b1;
				cmd.kind = bgnc_pkg::EMIT_EDGE;
				cmd.last = !sts.fl;
			end
			ST_FRD: begin
				cmd.fl_read = 1'b1;
			end
			ST_FSH: begin
				cmd.fl_shift = 1'b1;
			end
			ST_FEMIT: begin
				cmd.emit = 1'b1;
				cmd.kind = bgnc_pkg::EMIT_FLUSH;
				cmd.last = sts.fl_last;
			end
			default: begin
				cmd.take = 1'b0;
			end
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);

endmodule

>>> hdl/bgnc_dp.sv
module bgnc_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bgnc_pkg::SIZE_W-1:0]    cfg_data,
	input  logic                           mine,
	input  bgnc_pkg::cmd_t                 cmd,
	output bgnc_pkg::status_t              sts,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [bgnc_pkg::COORD_W-1:0]   row_index,
	output logic [bgnc_pkg::COORD_W-1:0]   col_index,
	output logic [bgnc_pkg::CNT_W-1:0]     neighbor_count,
	output logic                           last
);

	localparam int CW = bgnc_pkg::CMP_W;
	localparam int PW = bgnc_pkg::POS_W;

	logic [bgnc_pkg::SIZE_W-1:0] grid_q;
	logic [PW-1:0]               row_q;
	logic [PW-1:0]               col_q;
	logic [PW-1:0]               cur_r_q;
	logic [PW-1:0]               cur_c_q;
	logic                        mine_q;
	logic [CW-1:0]               fp_q;
	logic [2:0]                  win_q [3];

	logic [CW-1:0]               side;
	logic [CW-1:0]               side_m1;
	logic [CW-1:0]               row_w;
	logic [CW-1:0]               col_w;
	logic [CW-1:0]               pos_c;
	logic [CW-1:0]               pos_r;
	logic [CW-1:0]               cur_r_w;
	logic [CW-1:0]               cur_c_w;
	logic [CW-1:0]               c_inc;
	logic [CW-1:0]               r_inc;
	logic [CW-1:0]               c_nx;
	logic [CW-1:0]               r_nx;

	logic [bgnc_pkg::LINE_W-1:0] rd_data;
	logic                        ram_re;
	logic [bgnc_pkg::ADDR_W-1:0] ram_raddr;
	logic [2:0]                  new_col;

	logic [CW-1:0]               row_o;
	logic [CW-1:0]               col_o;
	logic [2:0]                  cmask;
	logic [2:0]                  rmask;
	logic [bgnc_pkg::CNT_W-1:0]  cnt;
	logic                        out_load;

	logic                        out_valid_q;
	logic [bgnc_pkg::COORD_W-1:0] row_index_q;
	logic [bgnc_pkg::COORD_W-1:0] col_index_q;
	logic [bgnc_pkg::CNT_W-1:0]  count_q;
	logic                        last_q;

	// Effective side: zero acts as one, oversize clamps to the buffer
	always_comb begin
		if (grid_q == '0) begin
			side = CW'(1);
		end else if (CW'(grid_q) > CW'(bgnc_pkg::MAX_SIZE)) begin
			side = CW'(bgnc_pkg::MAX_SIZE);
		end else begin
			side = CW'(grid_q);
		end
	end
	assign side_m1 = side - CW'(1);

	// Raster position of the incoming cell
	assign row_w = CW'(row_q);
	assign col_w = CW'(col_q);
	assign pos_r = (row_w >= side || col_w >= side) ? '0 : row_w;
	assign pos_c = (row_w >= side || col_w >= side) ? '0 : col_w;

	assign cur_r_w = CW'(cur_r_q);
	assign cur_c_w = CW'(cur_c_q);

	// Position after the current cell
	always_comb begin
		c_inc = cur_c_w + CW'(1);
		r_inc = cur_r_w + CW'(1);
		if (c_inc >= side) begin
			c_nx = '0;
			r_nx = (r_inc >= side) ? '0 : r_inc;
		end else begin
			c_nx = c_inc;
			r_nx = cur_r_w;
		end
	end

	// Size register and raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q <= bgnc_pkg::SIZE_W'(bgnc_pkg::GRID_RESET);
			row_q  <= '0;
			col_q  <= '0;
		end else if (cfg_we) begin
			grid_q <= cfg_data;
			row_q  <= '0;
			col_q  <= '0;
		end else if (cmd.load) begin
			row_q <= r_nx[PW-1:0];
			col_q <= c_nx[PW-1:0];
		end
	end

	// Cell held while its line buffer word is read
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			cur_r_q <= pos_r[PW-1:0];
			cur_c_q <= pos_c[PW-1:0];
			mine_q  <= mine;
		end
	end

	// Flush read pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fp_q <= '0;
		end else if (cmd.load) begin
			fp_q <= '0;
		end else if (cmd.fl_shift) begin
			fp_q <= fp_q + CW'(1);
		end
	end

	// Line buffer: bit 1 the newer row, bit 0 the older
	assign ram_re    = cmd.take | cmd.fl_read;
	assign ram_raddr = cmd.take ? pos_c[bgnc_pkg::ADDR_W-1:0]
	                            : fp_q[bgnc_pkg::ADDR_W-1:0];

	bgnc_ram #(
		.WIDTH(bgnc_pkg::LINE_W),
		.DEPTH(bgnc_pkg::MAX_SIZE)
	) u_line (
		.clk  (clk),
		.we   (cmd.load),
		.waddr(cur_c_q[bgnc_pkg::ADDR_W-1:0]),
		.wdata({mine_q, rd_data[1]}),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rd_data)
	);

	// 3x3 window, column 0 oldest; beyond the right edge a column is empty
	always_comb begin
		if (cmd.load) begin
			new_col = {mine_q, rd_data};
		end else if (fp_q < side) begin
			new_col = {1'b0, rd_data};
		end else begin
			new_col = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load || cmd.fl_shift) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= new_col;
		end
	end

	// Result coordinates and which window cells lie inside the grid
	always_comb begin
		case (cmd.kind)
			bgnc_pkg::EMIT_EDGE: begin
				row_o = cur_r_w - CW'(1);
				col_o = cur_c_w;
				cmask = 3'b011 << 1;
				rmask = {2'b11, cur_r_w >= CW'(2)};
			end
			bgnc_pkg::EMIT_FLUSH: begin
				row_o = side_m1;
				col_o = fp_q - CW'(2);
				cmask = {fp_q <= side, 1'b1, fp_q >= CW'(3)};
				rmask = {1'b0, 1'b1, side >= CW'(2)};
			end
			default: begin
				row_o = cur_r_w - CW'(1);
				col_o = cur_c_w - CW'(1);
				cmask = {2'b11, cur_c_w >= CW'(2)};
				rmask = {2'b11, cur_r_w >= CW'(2)};
			end
		endcase
	end

	// Box sum over the masked window
	always_comb begin
		cnt = '0;
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 3; i++) begin
				cnt = cnt + bgnc_pkg::CNT_W'(win_q[k][i] & cmask[k] & rmask[i]);
			end
		end
	end

	// Output register
	assign out_load = cmd.emit && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			row_index_q <= bgnc_pkg::COORD_W'(row_o);
			col_index_q <= bgnc_pkg::COORD_W'(col_o);
			count_q     <= cnt;
			last_q      <= cmd.last;
		end
	end

	assign out_valid      = out_valid_q;
	assign row_index      = row_index_q;
	assign col_index      = col_index_q;
	assign neighbor_count = count_q;
	assign last           = last_q;

	// Status to the controller
	assign sts.e1       = (cur_r_w != '0) && (cur_c_w != '0);
	assign sts.e2       = (cur_r_w != '0) && (cur_c_w == side_m1);
	assign sts.fl       = (cur_r_w == side_m1) && (cur_c_w == side_m1);
	assign sts.fl_first = (fp_q == '0);
	assign sts.fl_last  = (fp_q == side + CW'(1));
	assign sts.out_free = !out_valid_q || out_ready;

endmodule

>>> tb/tb_binary_grid_neighbor_count.sv
module tb_binary_grid_neighbor_count;

	// One expected box sum, in output order
	typedef struct packed {
		logic [bgnc_pkg::COORD_W-1:0] row;
		logic [bgnc_pkg::COORD_W-1:0] col;
		logic [bgnc_pkg::CNT_W-1:0]   count;
		logic                         last;
	} box_sum_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [bgnc_pkg::SIZE_W-1:0]   grid_size = bgnc_pkg::SIZE_W'(bgnc_pkg::GRID_RESET);
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic                          mine = 1'b0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [bgnc_pkg::COORD_W-1:0]  row_index;
	logic [bgnc_pkg::COORD_W-1:0]  col_index;
	logic [bgnc_pkg::CNT_W-1:0]    neighbor_count;
	logic                          last;

	// Cells waiting to be sent and box sums waiting to come out
	logic     cell_q[$];
	box_sum_t box_sum_q[$];
	int       cells_queued = 0;
	int       cells_sent = 0;
	int       mismatch_cnt = 0;

	// Predictor state: three rows of cells, raster position, side register
	logic                        cell_map [3][bgnc_pkg::MAX_SIZE];
	int                          ras_row = 0;
	int                          ras_col = 0;
	logic [bgnc_pkg::SIZE_W-1:0] side_reg = bgnc_pkg::SIZE_W'(bgnc_pkg::GRID_RESET);

	// Sender burst/gap state and receiver stall state
	int burst_left = 1;
	int gap_left = 0;
	int hold_asks = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int mode_left = 0;
	int ready_mode = 0;

	box_sum_t want;

	binary_grid_neighbor_count DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.grid_size      (grid_size),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mine           (mine),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.row_index      (row_index),
		.col_index      (col_index),
		.neighbor_count (neighbor_count),
		.last           (last)
	);

	always #5 clk = ~clk;

	// Effective side: 0 behaves as 1, oversize clamps to the buffer width
	function automatic int clamp_side(input logic [bgnc_pkg::SIZE_W-1:0] s);
		if (s == 0)
			return 1;
		if (int'(s) > bgnc_pkg::MAX_SIZE)
			return bgnc_pkg::MAX_SIZE;
		return int'(s);
	endfunction

	// Mines in the 3x3 box round (i,j); off-grid cells are empty
	function automatic logic [bgnc_pkg::CNT_W-1:0] box_count(input int i, input int j,
		input int n);
		int sum;
		sum = 0;
		for (int y = i - 1; y <= i + 1; y++)
			for (int x = j - 1; x <= j + 1; x++)
				if (y >= 0 && x >= 0 && y < n && x < n)
					sum += int'(cell_map[y % 3][x]);
		return bgnc_pkg::CNT_W'(sum);
	endfunction

	function automatic void expect_cell(input int i, input int j, input int n,
		input logic fin);
		box_sum_t e;
		e.row   = bgnc_pkg::COORD_W'(i);
		e.col   = bgnc_pkg::COORD_W'(j);
		e.count = box_count(i, j, n);
		e.last  = fin;
		box_sum_q.push_back(e);
	endfunction

	// Store one cell and queue every box sum it releases
	function automatic void predict_box_sums(input logic m);
		int   n, r, c;
		logic at_diag, at_edge, at_flush;
		n = clamp_side(side_reg);
		r = ras_row;
		c = ras_col;
		if (r >= n || c >= n) begin
			r = 0;
			c = 0;
		end
		cell_map[r % 3][c] = m;
		at_diag  = (r >= 1) && (c >= 1);
		at_edge  = (r >= 1) && (c == n - 1);
		at_flush = (r == n - 1) && (c == n - 1);
		if (at_diag)
			expect_cell(r - 1, c - 1, n, !at_edge && !at_flush);
		if (at_edge)
			expect_cell(r - 1, c, n, !at_flush);
		// last cell of the grid: whole bottom row comes out
		if (at_flush)
			for (int j = 0; j < n; j++)
				expect_cell(r, j, n, j == n - 1);
		c++;
		if (c >= n) begin
			c = 0;
			r++;
			if (r >= n)
				r = 0;
		end
		ras_row = r;
		ras_col = c;
	endfunction

	task automatic offer_bit(input logic b);
		cell_q.push_back(b);
		cells_queued++;
	endtask

	// density 0..4 in quarters: 0 gives all empty, 4 all mines
	task automatic offer_cells(input int count, input int density);
		for (int k = 0; k < count; k++)
			offer_bit($urandom_range(0, 3) < density);
	endtask

	// Wait until every cell is taken and every box sum has come out
	task automatic drain_all();
		while (cells_sent != cells_queued || box_sum_q.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_side(input logic [bgnc_pkg::SIZE_W-1:0] v);
		drain_all();
		@(posedge clk);
		cfg_valid <= 1'b1;
		grid_size <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		// a write also restarts the raster
		side_reg = v;
		ras_row = 0;
		ras_col = 0;
	endtask

	// Sender: bursts of cells with random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				predict_box_sums(mine);
				cells_sent++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (cell_q.size() != 0) begin
					in_valid <= 1'b1;
					mine <= cell_q.pop_front();
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: long hold-off on request, otherwise a changing stall mode
	always @(posedge clk) begin
		if (hold_asks != hold_seen) begin
			hold_seen <= hold_asks;
			hold_left <= 400;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				mode_left <= $urandom_range(40, 160);
				ready_mode <= $urandom_range(0, 3);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (ready_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= $urandom_range(0, 1);
				2: out_ready <= ($urandom_range(0, 7) != 0);
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Check each result transaction against the oldest expected box sum
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (box_sum_q.size() == 0) begin
				$display("%0t: unexpected result: expected none, got row %0d col %0d",
					$time, row_index, col_index);
				$display("%0t: unexpected result: count %0d last %0b",
					$time, neighbor_count, last);
				mismatch_cnt++;
			end else begin
				want = box_sum_q.pop_front();
				if (row_index !== want.row) begin
					$display("%0t: row_index expected %0d got %0d", $time, want.row, row_index);
					mismatch_cnt++;
				end
				if (col_index !== want.col) begin
					$display("%0t: col_index expected %0d got %0d", $time, want.col, col_index);
					mismatch_cnt++;
				end
				if (neighbor_count !== want.count) begin
					$display("%0t: neighbor_count at (%0d,%0d) expected %0d got %0d",
						$time, want.row, want.col, want.count, neighbor_count);
					mismatch_cnt++;
				end
				if (last !== want.last) begin
					$display("%0t: last at (%0d,%0d) expected %0b got %0b",
						$time, want.row, want.col, want.last, last);
					mismatch_cnt++;
				end
			end
		end
	end

	// Stimulus
	initial begin
		int sz, n, cnt, pick, phase, rand_items;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < bgnc_pkg::MAX_SIZE; j++)
				cell_map[i][j] = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// first rows of a grid at the reset side; receiver holds off part-way through
		offer_cells(3 * bgnc_pkg::MAX_SIZE, $urandom_range(1, 3));
		repeat (60) @(posedge clk);
		hold_asks++;

		// side 0 acts as 1: every cell is a grid of its own
		write_side('0);
		offer_bit(1'b1);
		offer_bit(1'b0);
		write_side(bgnc_pkg::SIZE_W'(1));
		offer_bit(1'b1);
		// stop part-way through a grid, then rewrite to restart the raster
		write_side(bgnc_pkg::SIZE_W'(2));
		offer_bit(1'b1);
		offer_bit(1'b1);
		offer_bit(1'b1);
		write_side(bgnc_pkg::SIZE_W'(3));
		offer_cells(9, 4);
		for (int k = 0; k < 9; k++)
			offer_bit(k[0] == 1'b0);

		// random phases, mostly small grids
		phase = 0;
		rand_items = 0;
		while (rand_items < 200) begin
			pick = $urandom_range(0, 19);
			if (phase == 0)
				sz = 63;
			else if (phase == 1)
				sz = 33;
			else if (pick < 2)
				sz = $urandom_range(33, 63);
			else if (pick < 3)
				sz = 0;
			else if (pick < 6)
				sz = $urandom_range(7, 16);
			else
				sz = $urandom_range(1, 6);
			if (phase < 2 || $urandom_range(0, 3) != 0)
				write_side(bgnc_pkg::SIZE_W'(sz));
			if (phase == 2)
				hold_asks++;
			n = clamp_side(side_reg);
			if (n > 16)
				cnt = $urandom_range(n + 2, 3 * n);
			else if (n > 6)
				cnt = ($urandom_range(0, 1) == 0) ? n * n : $urandom_range(1, n * n);
			else if ($urandom_range(0, 3) == 0)
				cnt = $urandom_range(1, n * n);
			else
				cnt = n * n * $urandom_range(1, 2);
			// keep the total near the planned item count
			if (cnt > 200 - rand_items)
				cnt = 200 - rand_items;
			offer_cells(cnt, $urandom_range(0, 4));
			rand_items += cnt;
			phase++;
		end

		drain_all();
		repeat (40) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("tb_binary_grid_neighbor_count: done, clean");
		else
			$display("tb_binary_grid_neighbor_count: done, errors");
		$finish;
	end

	// Watchdog
	initial begin
		#5000000;
		$display("tb_binary_grid_neighbor_count: done, errors");
		$finish;
	end

endmodule
